>>> rtl/core/rmcf_pkg.sv
package rmcf_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W = 48;
	localparam int KIND_W = 8;
	localparam int ENTRY_W = 2 * ADDR_W + KIND_W;
	localparam logic [KIND_W-1:0] AVAIL_KIND_RESET = 8'd1;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_CUT    = 2'd1,
		CMD_ALLOC  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOFIT  = 2'd1,
		ST_FULL   = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_WAIT,
		S_EVAL,
		S_TAIL,
		S_CPRD,
		S_CPWAIT,
		S_CPWR,
		S_DONE
	} state_t;

	// one table entry: kind, length, base from the top down
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] len;
		logic [ADDR_W-1:0] base;
	} entry_t;

endpackage

>>> rtl/core/rmcf_ram.sv
module rmcf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/region_map_cut_and_first_fit.sv
// after accept, append writes one entry; allocate reads and checks entries in turn until
// one fits; cut reads and checks every entry, with an extra tail step when the entry meets
// the range, staging the pieces, then copies the staged pieces back into the table
// throughput: one item at a time, set by the table and staging memories, each with one
// write and one read port; no new item until the result is taken
// reset: arst_n clears region count, sequencer and output valid; available_type goes to 1;
// table contents are undefined until written
module region_map_cut_and_first_fit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// command[1:0], entry_base[49:2], entry_length[97:50], entry_type[105:98],
	// cut_first[137:106], cut_end[169:138], alloc_size[201:170], zero fill to 208
	input  logic [207:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// alloc_address[47:0], status[49:48], region_total[55:50]
	output logic [55:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [1:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import rmcf_pkg::*;

	state_t state_q, state_d;
	logic [KIND_W-1:0] avail_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q, nstage_q;
	logic [1:0] cmd_q;
	logic [ADDR_W-1:0] ebase_q, elen_q;
	logic [KIND_W-1:0] ekind_q;
	logic [31:0] lo_q, hi_q, size_q;
	logic [ADDR_W-1:0] addr_q;
	status_t status_q;
	logic out_v_q;
	logic [55:0] out_q;
	entry_t cur_q;
	logic [ADDR_W:0] end_q;

	// table and staging memories
	logic t_we, s_we;
	logic [IDX_W-1:0] t_waddr, t_raddr, s_waddr, s_raddr;
	entry_t t_wdata, t_rdata, s_wdata, s_rdata;

	rmcf_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.raddr(t_raddr), .rdata(t_rdata));
	rmcf_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_stage (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rdata));

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {24'd0, avail_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avail_q <= AVAIL_KIND_RESET;
		end else if (psel && penable && pwrite && paddr == 2'd0) begin
			avail_q <= pwdata[KIND_W-1:0];
		end
	end

	assign s_tready = (state_q == S_IDLE) && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata = out_q;

	// compare terms on the current entry: overlap, head and tail for cut, fit for alloc
	logic [ADDR_W:0] lo_x, hi_x, b_x;
	logic overlap_n, head_v, tail_v, fits;
	assign lo_x = {17'd0, lo_q};
	assign hi_x = {17'd0, hi_q};
	assign b_x = {1'b0, cur_q.base};
	assign overlap_n = (hi_x <= b_x) || (end_q <= lo_x);
	assign head_v = b_x < lo_x;
	assign tail_v = hi_x < end_q;
	assign fits = (cur_q.kind == avail_q) && (cur_q.len >= {16'd0, size_q});

	logic idx_end;
	assign idx_end = idx_q >= count_q;

	always_comb begin
		state_d = state_q;
		t_we = 1'b0;
		s_we = 1'b0;
		t_waddr = idx_q[IDX_W-1:0];
		t_raddr = idx_q[IDX_W-1:0];
		s_waddr = nstage_q[IDX_W-1:0];
		s_raddr = idx_q[IDX_W-1:0];
		t_wdata = '{kind: ekind_q, len: elen_q, base: ebase_q};
		s_wdata = cur_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid && s_tready) state_d = S_RD;
			end
			S_RD: begin
				case (cmd_q)
					CMD_APPEND: begin
						t_waddr = count_q[IDX_W-1:0];
						t_we = (count_q < CNT_W'(TABLE_DEPTH));
						state_d = S_DONE;
					end
					// an overflowing cut leaves the table as it was
					CMD_CUT: begin
						if (status_q == ST_FULL) state_d = S_DONE;
						else state_d = (lo_q >= hi_q || idx_end) ? S_CPRD : S_WAIT;
					end
					CMD_ALLOC: state_d = idx_end ? S_DONE : S_WAIT;
					default: state_d = S_DONE;
				endcase
			end
			S_WAIT: state_d = S_EVAL;
			S_EVAL: begin
				if (cmd_q == CMD_ALLOC) begin
					if (fits) begin
						t_we = 1'b1;
						t_wdata = '{kind: cur_q.kind, len: cur_q.len - {16'd0, size_q},
							base: cur_q.base + {16'd0, size_q}};
						state_d = S_DONE;
					end else begin
						state_d = S_RD;
					end
				end else if (status_q == ST_FULL) begin
					state_d = S_DONE;
				end else if (overlap_n) begin
					s_we = nstage_q < CNT_W'(TABLE_DEPTH);
					state_d = S_RD;
				end else begin
					s_wdata = '{kind: cur_q.kind, len: lo_x[ADDR_W-1:0] - cur_q.base,
						base: cur_q.base};
					s_we = head_v && nstage_q < CNT_W'(TABLE_DEPTH);
					state_d = S_TAIL;
				end
			end
			S_TAIL: begin
				s_wdata = '{kind: cur_q.kind, len: end_q[ADDR_W-1:0] - hi_x[ADDR_W-1:0],
					base: hi_x[ADDR_W-1:0]};
				s_we = tail_v && nstage_q < CNT_W'(TABLE_DEPTH) && status_q != ST_FULL;
				state_d = (status_q == ST_FULL) ? S_DONE : S_RD;
			end
			S_CPRD: state_d = (lo_q >= hi_q || idx_q >= nstage_q) ? S_DONE : S_CPWAIT;
			S_CPWAIT: state_d = S_CPWR;
			S_CPWR: begin
				t_waddr = idx_q[IDX_W-1:0];
				t_wdata = s_rdata;
				t_we = 1'b1;
				state_d = S_CPRD;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath and bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_v_q <= 1'b0;
			idx_q <= '0;
			nstage_q <= '0;
			status_q <= ST_OK;
		end else begin
			if (m_tvalid && m_tready) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						cmd_q <= s_tdata[1:0];
						ebase_q <= s_tdata[49:2];
						elen_q <= s_tdata[97:50];
						ekind_q <= s_tdata[105:98];
						lo_q <= s_tdata[137:106];
						hi_q <= s_tdata[169:138];
						size_q <= s_tdata[201:170];
						idx_q <= '0;
						nstage_q <= '0;
						addr_q <= '0;
						status_q <= (s_tdata[1:0] == CMD_ALLOC) ? ST_NOFIT : ST_OK;
					end
				end
				S_RD: begin
					if (cmd_q == CMD_APPEND) begin
						if (count_q < CNT_W'(TABLE_DEPTH)) count_q <= count_q + 1'b1;
						else status_q <= ST_FULL;
					end
					if (cmd_q == CMD_CUT && (lo_q >= hi_q || idx_end)) idx_q <= '0;
				end
				S_WAIT: begin
					cur_q <= t_rdata;
					end_q <= {1'b0, t_rdata.base} + {1'b0, t_rdata.len};
				end
				S_EVAL: begin
					idx_q <= idx_q + 1'b1;
					if (cmd_q == CMD_ALLOC) begin
						if (fits) begin
							addr_q <= cur_q.base;
							status_q <= ST_OK;
						end
					end else if (overlap_n) begin
						if (nstage_q >= CNT_W'(TABLE_DEPTH)) status_q <= ST_FULL;
						else nstage_q <= nstage_q + 1'b1;
					end else if (head_v) begin
						if (nstage_q >= CNT_W'(TABLE_DEPTH)) status_q <= ST_FULL;
						else nstage_q <= nstage_q + 1'b1;
					end
				end
				S_TAIL: begin
					if (status_q != ST_FULL && tail_v) begin
						if (nstage_q >= CNT_W'(TABLE_DEPTH)) status_q <= ST_FULL;
						else nstage_q <= nstage_q + 1'b1;
					end
				end
				S_CPWR: idx_q <= idx_q + 1'b1;
				S_CPRD: begin
					if (lo_q < hi_q && idx_q >= nstage_q) count_q <= nstage_q;
				end
				S_DONE: begin
					out_v_q <= 1'b1;
					out_q <= {count_q, status_q, addr_q};
				end
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/core/rmcf_checker.sv
module rmcf_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [55:0]  m_tdata
);
	import rmcf_pkg::*;

	// result stays until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped while stalled");

	// no new item while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("ready while result pending");

	// status never holds the unused code
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[49:48] != 2'd3)
		else $error("bad status");

	// region total never exceeds table depth
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[55:50] <= 6'(TABLE_DEPTH))
		else $error("region total too large");

	// failed or non-alloc result has zero address when status not ok
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[49:48] != 2'd0 |-> m_tdata[47:0] == 48'd0)
		else $error("address on failure");

endmodule

bind region_map_cut_and_first_fit rmcf_checker u_rmcf_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import rmcf_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [31:0] size;
		logic [31:0] hi;
		logic [31:0] lo;
		logic [7:0]  kind;
		logic [47:0] len;
		logic [47:0] base;
		cmd_t        cmd;
	} request_t;

	typedef struct packed {
		logic [5:0]  total;
		status_t     status;
		logic [47:0] addr;
	} outcome_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [207:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [55:0]  m_tdata;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [1:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	region_map_cut_and_first_fit uut (.*);

	// predictor state
	logic [47:0] tbl_base [TABLE_DEPTH];
	logic [47:0] tbl_len [TABLE_DEPTH];
	logic [7:0]  tbl_kind [TABLE_DEPTH];
	int          tbl_count;
	logic [7:0]  avail_kind;

	request_t pending_items[$];
	outcome_t expected_outcomes[$];
	int       mismatches;
	int       idle_cycles;
	int       burst_left;
	int       gap_left;
	int       stall_mode;
	bit       timed_out;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// cut [lo,hi) out of every region, keeping order
	function automatic status_t predict_cut(logic [31:0] lo, logic [31:0] hi);
		logic [47:0] nb [TABLE_DEPTH];
		logic [47:0] nl [TABLE_DEPTH];
		logic [7:0]  nk [TABLE_DEPTH];
		int          n;
		logic [48:0] b;
		logic [48:0] e;
		n = 0;
		if (lo >= hi)
			return ST_OK;
		for (int i = 0; i < tbl_count; i++) begin
			b = {1'b0, tbl_base[i]};
			e = b + tbl_len[i];
			if (49'(hi) <= b || e <= 49'(lo)) begin
				if (n >= TABLE_DEPTH)
					return ST_FULL;
				nb[n] = tbl_base[i]; nl[n] = tbl_len[i]; nk[n] = tbl_kind[i]; n++;
				continue;
			end
			if (b < 49'(lo)) begin
				if (n >= TABLE_DEPTH)
					return ST_FULL;
				nb[n] = tbl_base[i]; nl[n] = 48'(49'(lo) - b); nk[n] = tbl_kind[i]; n++;
			end
			if (49'(hi) < e) begin
				if (n >= TABLE_DEPTH)
					return ST_FULL;
				nb[n] = 48'(hi); nl[n] = 48'(e - 49'(hi)); nk[n] = tbl_kind[i]; n++;
			end
		end
		for (int i = 0; i < n; i++) begin
			tbl_base[i] = nb[i]; tbl_len[i] = nl[i]; tbl_kind[i] = nk[i];
		end
		tbl_count = n;
		return ST_OK;
	endfunction

	function automatic outcome_t predict_region_map(request_t r);
		outcome_t o;
		o.addr = '0;
		o.status = ST_OK;
		case (r.cmd)
			CMD_APPEND: begin
				if (tbl_count >= TABLE_DEPTH)
					o.status = ST_FULL;
				else begin
					tbl_base[tbl_count] = r.base;
					tbl_len[tbl_count] = r.len;
					tbl_kind[tbl_count] = r.kind;
					tbl_count++;
				end
			end
			CMD_CUT: o.status = predict_cut(r.lo, r.hi);
			CMD_ALLOC: begin
				o.status = ST_NOFIT;
				for (int i = 0; i < tbl_count; i++) begin
					if (tbl_kind[i] == avail_kind && tbl_len[i] >= 48'(r.size)) begin
						o.addr = tbl_base[i];
						tbl_len[i] = tbl_len[i] - 48'(r.size);
						tbl_base[i] = tbl_base[i] + 48'(r.size);
						o.status = ST_OK;
						break;
					end
				end
			end
			default: ;
		endcase
		o.total = 6'(tbl_count);
		return o;
	endfunction

	function automatic request_t make_request(cmd_t c, logic [47:0] b, logic [47:0] l,
			logic [7:0] k, logic [31:0] lo, logic [31:0] hi, logic [31:0] sz);
		request_t r;
		r.cmd = c; r.base = b; r.len = l; r.kind = k;
		r.lo = lo; r.hi = hi; r.size = sz;
		return r;
	endfunction

	function automatic logic [47:0] rand48();
		return {16'($urandom), $urandom};
	endfunction

	// random item, mostly small addresses so cuts and allocs hit regions
	function automatic request_t random_request(logic [7:0] akind);
		request_t r;
		int sel;
		logic [31:0] lo;
		sel = $urandom_range(0, 99);
		r = request_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom});
		if (sel < 40) begin
			r.cmd = CMD_APPEND;
			if ($urandom_range(0, 3) != 0) begin
				r.base = 48'($urandom_range(0, 1 << 20));
				r.len = 48'($urandom_range(0, 1 << 16));
				r.kind = ($urandom_range(0, 2) != 0) ? akind : 8'($urandom);
			end else if ($urandom_range(0, 1) != 0) begin
				r.base = rand48();
				r.len = rand48();
			end
		end else if (sel < 65) begin
			r.cmd = CMD_CUT;
			if ($urandom_range(0, 3) != 0) begin
				lo = $urandom_range(0, 1 << 20);
				r.lo = lo;
				r.hi = lo + $urandom_range(0, 1 << 14);
				if ($urandom_range(0, 9) == 0)
					r.hi = lo - $urandom_range(0, 100);
			end
		end else if (sel < 97) begin
			r.cmd = CMD_ALLOC;
			if ($urandom_range(0, 3) != 0)
				r.size = $urandom_range(0, 1 << 12);
		end else
			r.cmd = cmd_t'(2'd3);
		return r;
	endfunction

	task automatic apb_write(logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= '0; pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		avail_kind = value;
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// sender: bursts and gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_outcomes.push_back(predict_region_map(pending_items.pop_front()));
			end
			if (s_tvalid && !s_tready) begin
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= {6'd0, pending_items[0]};
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 8);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
				end else
					burst_left <= burst_left - 1;
			end else
				s_tvalid <= 1'b0;
		end
	end

	// receiver: stall pattern switches between modes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_mode <= 0;
		end else begin
			if ($urandom_range(0, 63) == 0)
				stall_mode <= $urandom_range(0, 2);
			case (stall_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 1) != 0);
				default: m_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// checker and idle watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				outcome_t got;
				outcome_t want;
				got = m_tdata;
				if (expected_outcomes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %h", m_tdata);
				end else begin
					want = expected_outcomes.pop_front();
					if (got.addr !== want.addr || got.status !== want.status ||
							got.total !== want.total) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp addr %h status %0d total %0d, ",
								"got addr %h status %0d total %0d"},
								want.addr, want.status, want.total,
								got.addr, got.status, got.total);
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
				idle_cycles <= 0;
			else if (pending_items.size() != 0 || expected_outcomes.size() != 0) begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= IDLE_LIMIT)
					timed_out <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (timed_out) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	logic [7:0] kind_settings [4] = '{8'd1, 8'd0, 8'd255, 8'd7};

	initial begin
		mismatches = 0;
		idle_cycles = 0;
		timed_out = 1'b0;
		tbl_count = 0;
		avail_kind = AVAIL_KIND_RESET;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes, zero-length, split, wrap, fill
		pending_items.push_back(make_request(CMD_ALLOC, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(make_request(CMD_CUT, 0, 0, 0, 0, 32'hffffffff, 0));
		pending_items.push_back(make_request(CMD_APPEND, 0, 48'hffffffffffff, 8'd1, 0, 0, 0));
		pending_items.push_back(make_request(CMD_APPEND, 48'hffffffffffff, 48'hffffffffffff,
			8'hff, 0, 0, 0));
		pending_items.push_back(make_request(CMD_APPEND, 48'd500, 0, 8'd1, 0, 0, 0));
		pending_items.push_back(make_request(CMD_APPEND, 48'h1000, 48'h1000, 8'd1, 0, 0, 0));
		pending_items.push_back(make_request(CMD_ALLOC, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(make_request(CMD_ALLOC, 0, 0, 0, 0, 0, 32'h10));
		pending_items.push_back(make_request(CMD_CUT, 0, 0, 0, 32'd10, 32'd10, 0));
		pending_items.push_back(make_request(CMD_CUT, 0, 0, 0, 32'd20, 32'd10, 0));
		pending_items.push_back(make_request(CMD_CUT, 0, 0, 0, 32'd100, 32'd1000, 0));
		pending_items.push_back(make_request(CMD_CUT, 0, 0, 0, 32'h1400, 32'h1800, 0));
		pending_items.push_back(make_request(CMD_ALLOC, 0, 0, 0, 0, 0, 32'hffffffff));
		pending_items.push_back(make_request(CMD_ALLOC, 0, 0, 0, 0, 0, 32'h300));
		pending_items.push_back(make_request(cmd_t'(2'd3), '1, '1, '1, '1, '1, '1));
		for (int i = 0; i < 30; i++)
			pending_items.push_back(make_request(CMD_APPEND, 48'(i * 64), 48'd32, 8'd1, 0, 0, 0));
		pending_items.push_back(make_request(CMD_CUT, 0, 0, 0, 32'd4, 32'd8, 0));
		pending_items.push_back(make_request(CMD_CUT, 0, 0, 0, 0, 32'hffffffff, 0));
		wait_drained();

		// random phases across register settings
		for (int p = 0; p < 4; p++) begin
			apb_write(kind_settings[p]);
			for (int i = 0; i < 225; i++) begin
				if ($urandom_range(0, 60) == 0)
					pending_items.push_back(make_request(CMD_CUT, 0, 0, 0, 0, 32'hffffffff, 0));
				else
					pending_items.push_back(random_request(kind_settings[p]));
			end
			wait_drained();
		end

		if (mismatches == 0 && expected_outcomes.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
